>>> hdl/tp_pkg.sv
// Shared types and constants for the threshold partition block.
// Has no dependencies. The sequencer, the top level and the testbench use it.
`default_nettype none

package tp_pkg;

  // Widths of the payload fields.
  localparam int unsigned IDX_W = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned LCNT_W = 7;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic [LCNT_W-1:0]        lcnt_t;

  // One stored element: sample index and feature value.
  typedef struct packed {
    idx_t idx;
    val_t val;
  } entry_t;

  // Strobe and side fields from the sequencer that load the output register.
  typedef struct packed {
    logic  load;
    logic  last;
    logic  overflow;
    lcnt_t low_count;
  } emit_t;

endpackage

`default_nettype wire

>>> hdl/tp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// Has no dependencies.
`default_nettype none

module tp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/tp_seq.sv
// Sequencer of the threshold partition block: load, in-place partition, readout.
// Depends on tp_pkg. Drives the element RAM (tp_ram) that the top level instantiates.
`default_nettype none

module tp_seq #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire tp_pkg::idx_t                   in_sample_index,
  input  wire tp_pkg::val_t                   in_feature_value,
  input  wire logic                           in_last,
  input  wire tp_pkg::val_t                   threshold,
  output logic                                ram_we,
  output logic [$clog2(MAX_ITEMS)-1:0]        ram_waddr,
  output tp_pkg::entry_t                      ram_wdata,
  output logic [$clog2(MAX_ITEMS)-1:0]        ram_raddr,
  input  wire tp_pkg::entry_t                 ram_rdata,
  input  wire logic                           out_done,
  output tp_pkg::emit_t                       emit,
  output logic                                idle
);
  import tp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  typedef enum logic [7:0] {
    ST_LOAD = 8'b0000_0001,
    ST_SCAN = 8'b0000_0010,
    ST_TEST = 8'b0000_0100,
    ST_SWA  = 8'b0000_1000,
    ST_SWB  = 8'b0001_0000,
    ST_ORD  = 8'b0010_0000,
    ST_OLD  = 8'b0100_0000,
    ST_OWT  = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] e_r, e_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          last_r, last_nxt;
  entry_t        a_r, a_nxt;
  logic          accept;
  logic          has_room;
  logic [CW-1:0] e_dec;

  assign accept   = in_valid && (state_r == ST_LOAD);
  assign has_room = (fill_r < CNT_MAX);
  assign e_dec    = e_r - CNT_ONE;
  assign in_stall = (state_r != ST_LOAD);
  assign idle     = (state_r == ST_LOAD);

  // Next-state logic and RAM access for each step of the sequence.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    drop_nxt  = drop_r;
    p_nxt     = p_r;
    e_nxt     = e_r;
    k_nxt     = k_r;
    last_nxt  = last_r;
    a_nxt     = a_r;
    ram_we    = 1'b0;
    ram_waddr = fill_r[AW-1:0];
    ram_wdata = '{idx: in_sample_index, val: in_feature_value};
    ram_raddr = p_r[AW-1:0];
    emit      = '{load: 1'b0, last: last_r, overflow: drop_r, low_count: lcnt_t'(e_r)};

    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          // Store the element if there is room, otherwise remember the drop.
          if (has_room) begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + CNT_ONE;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            p_nxt     = '0;
            e_nxt     = has_room ? (fill_r + CNT_ONE) : fill_r;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Read the element at the scan position, or finish the partition.
        k_nxt = '0;
        if (p_r < e_r) begin
          state_nxt = ST_TEST;
        end else if (fill_r == '0) begin
          drop_nxt  = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_ORD;
        end
      end
      ST_TEST: begin
        // Low values advance the scan; high ones swap with the shrinking end.
        a_nxt = ram_rdata;
        if (ram_rdata.val <= threshold) begin
          p_nxt     = p_r + CNT_ONE;
          state_nxt = ST_SCAN;
        end else begin
          e_nxt     = e_dec;
          ram_raddr = e_dec[AW-1:0];
          state_nxt = ST_SWA;
        end
      end
      ST_SWA: begin
        // The end element moves to the scan position.
        ram_we    = 1'b1;
        ram_waddr = p_r[AW-1:0];
        ram_wdata = ram_rdata;
        state_nxt = ST_SWB;
      end
      ST_SWB: begin
        // The high element moves to the end position.
        ram_we    = 1'b1;
        ram_waddr = e_r[AW-1:0];
        ram_wdata = a_r;
        state_nxt = ST_SCAN;
      end
      ST_ORD: begin
        ram_raddr = k_r[AW-1:0];
        last_nxt  = (k_r == (fill_r - CNT_ONE));
        state_nxt = ST_OLD;
      end
      ST_OLD: begin
        emit.load = 1'b1;
        state_nxt = ST_OWT;
      end
      ST_OWT: begin
        // Wait for the result transfer, then read the next position or, after the last one, return to loading.
        if (out_done) begin
          if (last_r) begin
            fill_nxt  = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + CNT_ONE;
            state_nxt = ST_ORD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r  <= '0;
      drop_r  <= 1'b0;
      p_r     <= '0;
      e_r     <= '0;
      k_r     <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      drop_r  <= drop_nxt;
      p_r     <= p_nxt;
      e_r     <= e_nxt;
      k_r     <= k_nxt;
      last_r  <= last_nxt;
    end
  end

  // Held copy of the element under test during a swap.
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/threshold_partition_top.sv
// Top level of the threshold partition block: threshold register, element RAM,
// sequencer and output register. Depends on tp_pkg, tp_ram and tp_seq.
//
// Usage: write the signed threshold on the cfg_ channel (cfg_valid/cfg_ready)
// while the block is idle. Elements arrive on the in_ channel, one per cycle,
// and are taken while in_stall is low. Up to MAX_ITEMS elements are stored;
// further ones are dropped and flag out_overflow. The element with in_last set
// closes the segment and starts an in-place two-pointer partition: each step
// reads one element from the element RAM (ST_SCAN and ST_TEST for a low value,
// plus ST_SWA and ST_SWB for a high value, which is swapped with the element
// before the end pointer). The partitioned elements then leave on the out_
// channel in position order, each read only after the previous result has
// transferred, each with the low-side count; out_last_out marks the final one.
// in_stall stays high from the last element until the final result transfer.
// A stalled result is held in the output register until out_stall drops. Reset
// (rst_n low, synchronous) empties the segment and sets the threshold to zero;
// RAM contents are not cleared and need not be.
`default_nettype none

module threshold_partition_top #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire tp_pkg::val_t   cfg_data,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire tp_pkg::idx_t   in_sample_index,
  input  wire tp_pkg::val_t   in_feature_value,
  input  wire logic           in_last,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tp_pkg::idx_t        out_index,
  output tp_pkg::val_t        out_value,
  output tp_pkg::lcnt_t       out_low_count,
  output logic                out_overflow,
  output logic                out_last_out
);
  import tp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);

  val_t          thr_r;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;
  emit_t         emit;
  logic          idle;
  logic          out_done;
  logic          out_valid_r, out_valid_nxt;
  idx_t          out_index_r;
  val_t          out_value_r;
  lcnt_t         out_lcnt_r;
  logic          out_ovf_r;
  logic          out_last_r;

  assign cfg_ready = idle;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  tp_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tp_seq #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_index  (in_sample_index),
    .in_feature_value (in_feature_value),
    .in_last          (in_last),
    .threshold        (thr_r),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_done         (out_done),
    .emit             (emit),
    .idle             (idle)
  );

  // Output register: loaded from the RAM read data, valid cleared on transfer.
  assign out_done = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_done) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_index_r <= ram_rdata.idx;
      out_value_r <= ram_rdata.val;
      out_lcnt_r  <= emit.low_count;
      out_ovf_r   <= emit.overflow;
      out_last_r  <= emit.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_value     = out_value_r;
  assign out_low_count = out_lcnt_r;
  assign out_overflow  = out_ovf_r;
  assign out_last_out  = out_last_r;

endmodule

`default_nettype wire

>>> bench/tb_threshold_partition_top.sv
// Testbench for threshold_partition_top: sends segments of (sample index, feature value)
// pairs, predicts the partitioned order of every segment and checks each result transfer.
// Depends on tp_pkg and the threshold_partition_top RTL; it reads no files.

module tb_threshold_partition_top;
  import tp_pkg::*;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned PRINT_CAP = 40;
  localparam val_t VAL_MIN = val_t'(32'h8000_0000);
  localparam val_t VAL_MAX = val_t'(32'h7fff_ffff);

  // One input transfer and one predicted result transfer.
  typedef struct {
    idx_t idx;
    val_t val;
    logic last;
  } element_t;

  typedef struct {
    idx_t  idx;
    val_t  val;
    lcnt_t low_count;
    logic  overflow;
    logic  last;
  } split_result_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  val_t  cfg_data = '0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  idx_t  in_sample_index = '0;
  val_t  in_feature_value = '0;
  logic  in_last = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  idx_t  out_index;
  val_t  out_value;
  lcnt_t out_low_count;
  logic  out_overflow;
  logic  out_last_out;

  // Predictor state: the current segment, its drop flag and the threshold copy.
  idx_t          seg_index [STORE_DEPTH];
  val_t          seg_value [STORE_DEPTH];
  int unsigned   seg_fill = 0;
  logic          seg_dropped = 1'b0;
  val_t          split_threshold = '0;
  split_result_t split_results_q [$];
  element_t      pending_elements [$];

  logic          in_took = 1'b0;
  int unsigned   results_seen = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_left = 0;
  int unsigned   send_calm = 0;
  int unsigned   stall_left = 0;
  int unsigned   recv_calm = 0;
  int unsigned   hold_left = 0;
  int unsigned   holds_done = 0;
  int unsigned   next_hold_at = 30;

  threshold_partition_top #(
    .MAX_ITEMS(STORE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_index  (in_sample_index),
    .in_feature_value (in_feature_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_index        (out_index),
    .out_value        (out_value),
    .out_low_count    (out_low_count),
    .out_overflow     (out_overflow),
    .out_last_out     (out_last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length between transfers: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic idx_t pick_index();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return idx_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Values cluster at and around the threshold so both sides and ties are common.
  function automatic val_t pick_value(val_t thr);
    longint near_val;
    case ($urandom_range(0, 9))
      0: return thr;
      1: return VAL_MIN;
      2: return VAL_MAX;
      3, 4: begin
        near_val = longint'(thr) + longint'($urandom_range(0, 6)) - 3;
        if (near_val > longint'(VAL_MAX)) near_val = longint'(VAL_MAX);
        if (near_val < longint'(VAL_MIN)) near_val = longint'(VAL_MIN);
        return val_t'(near_val);
      end
      default: return val_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Store one accepted element; on the last one, partition the segment in place
  // with the two-pointer scan and queue one result per stored element.
  task automatic absorb_element(element_t elem);
    int unsigned   scan;
    int unsigned   split_end;
    idx_t          swap_idx;
    val_t          swap_val;
    split_result_t r;
    if (seg_fill < STORE_DEPTH) begin
      seg_index[seg_fill] = elem.idx;
      seg_value[seg_fill] = elem.val;
      seg_fill++;
    end else begin
      seg_dropped = 1'b1;
    end
    if (!elem.last) return;
    scan = 0;
    split_end = seg_fill;
    while (scan < split_end) begin
      if (seg_value[scan] <= split_threshold) begin
        scan++;
      end else begin
        split_end--;
        swap_idx = seg_index[scan];
        swap_val = seg_value[scan];
        seg_index[scan] = seg_index[split_end];
        seg_value[scan] = seg_value[split_end];
        seg_index[split_end] = swap_idx;
        seg_value[split_end] = swap_val;
      end
    end
    for (int unsigned k = 0; k < seg_fill; k++) begin
      r.idx = seg_index[k];
      r.val = seg_value[k];
      r.low_count = lcnt_t'(split_end);
      r.overflow = seg_dropped;
      r.last = (k + 1 == seg_fill);
      split_results_q.push_back(r);
    end
    seg_fill = 0;
    seg_dropped = 1'b0;
  endtask

  task automatic check_result();
    split_result_t want;
    results_seen++;
    if (split_results_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      return;
    end
    want = split_results_q.pop_front();
    if (out_index !== want.idx)
      report_mismatch($sformatf("result %0d index %h, expected %h",
                                results_seen, out_index, want.idx));
    if (out_value !== want.val)
      report_mismatch($sformatf("result %0d value %0d, expected %0d",
                                results_seen, out_value, want.val));
    if (out_low_count !== want.low_count)
      report_mismatch($sformatf("result %0d low count %0d, expected %0d",
                                results_seen, out_low_count, want.low_count));
    if (out_overflow !== want.overflow)
      report_mismatch($sformatf("result %0d overflow %b, expected %b",
                                results_seen, out_overflow, want.overflow));
    if (out_last_out !== want.last)
      report_mismatch($sformatf("result %0d last flag %b, expected %b",
                                results_seen, out_last_out, want.last));
  endtask

  // Monitor: threshold writes, input transfers into the predictor, result checks.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) split_threshold = cfg_data;
      in_took = in_valid && !in_stall;
      if (in_took) absorb_element('{idx: in_sample_index, val: in_feature_value, last: in_last});
      if (out_valid && !out_stall) check_result();
    end
  end

  // Driver: offers pending elements, holding each one until its transfer.
  always @(negedge clk) begin
    element_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_left > 0) begin
        send_left--;
        in_valid <= 1'b0;
      end else if (pending_elements.size() != 0) begin
        nxt = pending_elements.pop_front();
        in_valid <= 1'b1;
        in_sample_index <= nxt.idx;
        in_feature_value <= nxt.val;
        in_last <= nxt.last;
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_left = pick_gap();
          if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus two long hold-offs while the sender keeps offering.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && results_seen >= next_hold_at) begin
      hold_left = LONG_HOLD - 1;
      holds_done++;
      next_hold_at = 300;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (recv_calm > 0) begin
        recv_calm--;
      end else begin
        stall_left = pick_gap();
        if ($urandom_range(0, 59) == 0) recv_calm = $urandom_range(30, 120);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_element(idx_t idx, val_t val, logic last);
    element_t elem;
    elem.idx = idx;
    elem.val = val;
    elem.last = last;
    pending_elements.push_back(elem);
  endtask

  task automatic queue_segment(int unsigned len, val_t thr);
    for (int unsigned i = 0; i < len; i++)
      queue_element(pick_index(), pick_value(thr), i + 1 == len);
  endtask

  // Waits until every element is sent and every result has come back.
  task automatic wait_drained();
    while (pending_elements.size() != 0 || in_valid || split_results_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(val_t thr);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus: directed segments first, then random phases with a new threshold each.
  initial begin
    int unsigned queued;
    int unsigned phase_end;
    int unsigned seg_len;
    int unsigned phase;
    val_t        thr;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Threshold still at its reset value: a tie, a single high value, a mixed segment.
    queue_element(16'h0000, 32'sd0, 1'b1);
    queue_element(16'hffff, 32'sd1, 1'b1);
    queue_element(16'h1234, -32'sd1, 1'b0);
    queue_element(16'habcd, VAL_MAX, 1'b0);
    queue_element(16'h0001, VAL_MIN, 1'b0);
    queue_element(16'h0002, 32'sd0, 1'b0);
    queue_element(16'h0003, 32'sd1, 1'b1);
    wait_drained();

    // Largest threshold: everything lands on the low side.
    write_threshold(VAL_MAX);
    queue_element(16'h0007, VAL_MAX, 1'b0);
    queue_element(16'h0008, VAL_MIN, 1'b0);
    queue_element(16'h0009, val_t'(32'h5a5a_5a5a), 1'b1);
    wait_drained();

    // Smallest threshold: only the smallest value stays low.
    write_threshold(VAL_MIN);
    queue_element(16'h000a, VAL_MAX, 1'b0);
    queue_element(16'h000b, VAL_MIN, 1'b0);
    queue_element(16'h000c, VAL_MIN + 1, 1'b0);
    queue_element(16'h000d, -32'sd1, 1'b1);
    wait_drained();

    write_threshold(-32'sd1);
    queue_element(16'h8000, -32'sd1, 1'b0);
    queue_element(16'h7fff, 32'sd0, 1'b1);
    wait_drained();

    queued = 0;
    phase = 0;
    while (queued < RANDOM_ITEMS) begin
      case (phase % 6)
        1: thr = '0;
        2: thr = VAL_MAX;
        3: thr = VAL_MIN;
        4: thr = val_t'($urandom_range(0, 200)) - 100;
        default: thr = val_t'($urandom);
      endcase
      write_threshold(thr);

      // Some phases open with a full store: exactly full, last item dropped,
      // and several items dropped before the last.
      case (phase)
        1: seg_len = STORE_DEPTH;
        3: seg_len = STORE_DEPTH + 1;
        5: seg_len = STORE_DEPTH + 6;
        default: seg_len = 0;
      endcase
      if (seg_len != 0) begin
        queue_segment(seg_len, thr);
        queued += seg_len;
      end

      phase_end = queued + PHASE_ITEMS;
      while (queued < phase_end) begin
        if ($urandom_range(0, 11) == 0)
          seg_len = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 5);
        else
          seg_len = $urandom_range(1, 12);
        queue_segment(seg_len, thr);
        queued += seg_len;
      end
      wait_drained();
      phase++;
    end

    if (mismatch_count == 0 && split_results_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
